[hw/rtl/wtle_pkg.sv]
// Shared types, register codes and helpers for the waveform thick-line extruder.
`default_nettype none
package wtle_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_LEFT_X     = 3'd0;
  localparam logic [2:0] REG_X_STEP     = 3'd1;
  localparam logic [2:0] REG_CENTER_Y   = 3'd2;
  localparam logic [2:0] REG_AMPLITUDE  = 3'd3;
  localparam logic [2:0] REG_HALF_WIDTH = 3'd4;
  localparam logic [2:0] REG_T_STEP     = 3'd5;

  // Point index storage width (covers indexes up to 65535)
  localparam int IDX_W = 16;

  // Configuration register set
  typedef struct packed {
    logic signed [31:0] left_x;
    logic [30:0]        x_step;
    logic signed [31:0] center_y;
    logic [30:0]        amplitude;
    logic [23:0]        half_width;
    logic [16:0]        t_step;
  } cfg_t;

  // One point to extrude: its index, its sample, the chord ends and flags
  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic signed [15:0] sp;
    logic signed [15:0] sa;
    logic signed [15:0] sb;
    logic               dbl;
    logic               endf;
  } job_t;

  // Clamp a wide signed coordinate to 32 bits
  function automatic logic [31:0] sat32(input logic signed [47:0] v);
    logic [31:0] r;
    if (v > 48'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -48'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/waveform_thick_line_extruder_top.sv]
// Top level: configuration registers, sample front, point queue, geometry back end.
// Each point request that leaves the queue passes position, normalizing shifts, square
// root and divide; degenerate chords skip root and divide. The back end works one point
// (two vertices) at a time and takes no new request until both vertices are taken; its
// pace is set by the bit-serial square root and two dividers; a sample gives 0 to 2 points.
// Reset (synchronous, rst high) restores register defaults, empties window and queue.
`default_nettype none
module waveform_thick_line_extruder_top
  import wtle_pkg::*;
#(
  parameter int MAX_SAMPLES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [15:0] sample
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [87:0]      m_tdata,   // [31:0] vert_x, [63:32] vert_y, [80:64] tex_t
  output logic             m_tuser,   // [0] lower_side
  output logic             m_tlast,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  cfg_t        cfg;
  logic        room2, push0, push1, q_pop, q_empty;
  job_t        job0, job1, q_head;
  logic [31:0] vx, vy;
  logic [16:0] vt;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.left_x     <= '0;
      cfg.x_step     <= 31'd65536;
      cfg.center_y   <= '0;
      cfg.amplitude  <= 31'd65536;
      cfg.half_width <= 24'd65536;
      cfg.t_step     <= 17'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEFT_X:     cfg.left_x     <= cfg_data;
        REG_X_STEP:     cfg.x_step     <= cfg_data[30:0];
        REG_CENTER_Y:   cfg.center_y   <= cfg_data;
        REG_AMPLITUDE:  cfg.amplitude  <= cfg_data[30:0];
        REG_HALF_WIDTH: cfg.half_width <= cfg_data[23:0];
        REG_T_STEP:     cfg.t_step     <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  wtle_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_sample (s_tdata),
    .in_last   (s_tlast),
    .room2     (room2),
    .push0     (push0),
    .push1     (push1),
    .job0      (job0),
    .job1      (job1)
  );

  wtle_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push0 (push0),
    .push1 (push1),
    .job0  (job0),
    .job1  (job1),
    .room2 (room2),
    .pop   (q_pop),
    .empty (q_empty),
    .head  (q_head)
  );

  wtle_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_x     (vx),
    .out_y     (vy),
    .out_lower (m_tuser),
    .out_t     (vt),
    .out_end   (m_tlast)
  );

  assign m_tdata = {7'b0, vt, vy, vx};

endmodule
`default_nettype wire

[hw/rtl/wtle_queue.sv]
// Four-entry point queue between the sample front and the geometry back end.
`default_nettype none
module wtle_queue
  import wtle_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push0,
  input  wire logic push1,
  input  wire job_t job0,
  input  wire job_t job1,
  output logic      room2,
  input  wire logic pop,
  output logic      empty,
  output job_t      head
);

  job_t       mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;

  assign room2 = (count <= 3'd2);
  assign empty = (count == 3'd0);
  assign head  = mem[rd_ptr];

  // Store up to two points per cycle
  always_ff @(posedge clk) begin
    if (push0) begin
      mem[wr_ptr] <= job0;
    end
    if (push1) begin
      mem[wr_ptr + 2'd1] <= job1;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + {1'b0, push0} + {1'b0, push1};
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count + {2'b0, push0} + {2'b0, push1} - {2'b0, pop};
    end
  end

endmodule
`default_nettype wire

[hw/rtl/wtle_front.sv]
// Sample window: accepts samples and turns them into point requests.
`default_nettype none
module wtle_front
  import wtle_pkg::*;
#(
  parameter int MAX_SAMPLES = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_sample,
  input  wire logic               in_last,
  input  wire logic               room2,
  output logic                    push0,
  output logic                    push1,
  output job_t                    job0,
  output job_t                    job1
);

  localparam logic [IDX_W:0] IDX_LIMIT = (IDX_W+1)'(MAX_SAMPLES);

  logic signed [15:0] older_sample;
  logic signed [15:0] newer_sample;
  logic [1:0]         held_count;
  logic [IDX_W-1:0]   point_index;
  logic [IDX_W:0]     idx_inc;
  logic [IDX_W-1:0]   idx_next;
  logic               take;

  assign in_ready = room2;
  assign take     = in_valid & room2;
  assign idx_inc  = {1'b0, point_index} + 1'b1;
  assign idx_next = (idx_inc < IDX_LIMIT) ? idx_inc[IDX_W-1:0] : IDX_W'(MAX_SAMPLES - 1);

  // Build the point requests for this sample
  always_comb begin
    job0.idx  = point_index;
    job0.sp   = newer_sample;
    job0.sa   = in_sample;
    job0.sb   = (held_count == 2'd2) ? older_sample : newer_sample;
    job0.dbl  = (held_count == 2'd2);
    job0.endf = 1'b0;
    job1.idx  = idx_next;
    job1.sp   = in_sample;
    job1.sa   = in_sample;
    job1.sb   = newer_sample;
    job1.dbl  = 1'b0;
    job1.endf = 1'b1;
    push0     = take & (held_count != 2'd0);
    push1     = push0 & in_last;
  end

  // Slide the window
  always_ff @(posedge clk) begin
    if (rst) begin
      older_sample <= '0;
      newer_sample <= '0;
      held_count   <= '0;
      point_index  <= '0;
    end else if (take) begin
      if (held_count == 2'd0) begin
        newer_sample <= in_sample;
        point_index  <= '0;
        held_count   <= in_last ? 2'd0 : 2'd1;
      end else if (in_last) begin
        older_sample <= '0;
        newer_sample <= '0;
        held_count   <= 2'd0;
        point_index  <= '0;
      end else begin
        older_sample <= newer_sample;
        newer_sample <= in_sample;
        held_count   <= 2'd2;
        point_index  <= idx_next;
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/wtle_back.sv]
// Geometry back end: position, unit normal by root and divide, two vertices.
`default_nettype none
module wtle_back
  import wtle_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  q_empty,
  input  wire job_t  q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic [31:0] out_x,
  output logic [31:0] out_y,
  output logic        out_lower,
  output logic [16:0] out_t,
  output logic        out_end
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_YA   = 4'd1;
  localparam logic [3:0] S_YB   = 4'd2;
  localparam logic [3:0] S_YP   = 4'd3;
  localparam logic [3:0] S_X    = 4'd4;
  localparam logic [3:0] S_CHK  = 4'd5;
  localparam logic [3:0] S_NORM = 4'd6;
  localparam logic [3:0] S_SQA  = 4'd7;
  localparam logic [3:0] S_SQB  = 4'd8;
  localparam logic [3:0] S_SQRT = 4'd9;
  localparam logic [3:0] S_DIV  = 4'd10;
  localparam logic [3:0] S_MX   = 4'd11;
  localparam logic [3:0] S_MY   = 4'd12;
  localparam logic [3:0] S_OY   = 4'd13;
  localparam logic [3:0] S_VERT = 4'd14;
  localparam logic [3:0] S_OUT  = 4'd15;

  logic [3:0]         state;
  job_t               job;
  logic signed [47:0] prod;
  logic signed [35:0] ya, yb, yp, dy;
  logic signed [47:0] xpos;
  logic [16:0]        tex;
  logic [35:0]        nax, nay;
  logic [59:0]        sqx;
  logic [61:0]        sv;
  logic [32:0]        srem;
  logic [30:0]        sroot;
  logic [5:0]         cnt;
  logic [30:0]        dremx, dremy;
  logic [31:0]        dlowx, dlowy;
  logic [31:0]        qx, qy;
  logic [55:0]        pm;
  logic [26:0]        offx, offy;
  logic [31:0]        ux, uy, lx, ly;
  logic               upper_sent;

  logic signed [31:0] amp_s;
  logic signed [35:0] yv;
  logic signed [47:0] prnd;
  logic [31:0]        dx;
  logic [35:0]        ay_abs, mx;
  logic               degen;
  logic [34:0]        rem_t, trial;
  logic [60:0]        numx, numy;
  logic [31:0]        r2x, r2y;
  logic signed [47:0] oxs, oys;
  logic [32:0]        tm;

  assign amp_s  = $signed({1'b0, cfg.amplitude});
  assign prnd   = prod + 48'sd16384;
  assign yv     = 36'(cfg.center_y) - 36'(prnd >>> 15);
  assign dx     = job.dbl ? {cfg.x_step, 1'b0} : {1'b0, cfg.x_step};
  assign ay_abs = dy[35] ? 36'(-dy) : 36'(dy);
  assign mx     = (nax > nay) ? nax : nay;
  assign degen  = (dx <= 32'd65) && (ay_abs <= 36'd65) &&
                  (14'(dx[6:0] * dx[6:0]) + 14'(ay_abs[6:0] * ay_abs[6:0]) < 14'd4295);
  assign rem_t  = {srem, sv[61:60]};
  assign trial  = {2'b00, sroot, 2'b01};
  assign numx   = {1'b0, nay[29:0], 30'b0} + 61'(sroot >> 1);
  assign numy   = {1'b0, nax[29:0], 30'b0} + 61'(sroot >> 1);
  assign r2x    = {dremx, dlowx[31]};
  assign r2y    = {dremy, dlowy[31]};
  assign oxs    = dy > 36'sd0 ? -48'($signed({1'b0, offx})) : 48'($signed({1'b0, offx}));
  assign oys    = 48'($signed({1'b0, offy}));
  assign tm     = job.idx * cfg.t_step;

  assign q_pop     = (state == S_IDLE) & ~q_empty;
  assign out_valid = (state == S_OUT);
  assign out_x     = upper_sent ? lx : ux;
  assign out_y     = upper_sent ? ly : uy;
  assign out_lower = upper_sent;
  assign out_t     = tex;
  assign out_end   = upper_sent & job.endf;

  // Sequence one point through the shared arithmetic
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      upper_sent <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            job   <= q_head;
            state <= S_YA;
          end
        end
        S_YA: begin
          prod  <= job.sa * amp_s;
          state <= S_YB;
        end
        S_YB: begin
          ya    <= yv;
          prod  <= job.sb * amp_s;
          state <= S_YP;
        end
        S_YP: begin
          yb    <= yv;
          prod  <= job.sp * amp_s;
          state <= S_X;
        end
        S_X: begin
          yp    <= yv;
          dy    <= ya - yb;
          xpos  <= 48'(cfg.left_x) + $signed({1'b0, 47'(job.idx * cfg.x_step)});
          tex   <= (tm > 33'd65536) ? 17'd65536 : tm[16:0];
          state <= S_CHK;
        end
        S_CHK: begin
          nax <= 36'(dx);
          nay <= ay_abs;
          if (degen) begin
            offx  <= '0;
            offy  <= 27'(cfg.half_width);
            state <= S_VERT;
          end else begin
            state <= S_NORM;
          end
        end
        // Bring the larger part into [2^29, 2^30), one bit a cycle
        S_NORM: begin
          if (mx[35:30] != '0) begin
            nax <= nax >> 1;
            nay <= nay >> 1;
          end else if (!mx[29]) begin
            nax <= nax << 1;
            nay <= nay << 1;
          end else begin
            state <= S_SQA;
          end
        end
        S_SQA: begin
          sqx   <= nax[29:0] * nax[29:0];
          state <= S_SQB;
        end
        S_SQB: begin
          sv    <= 62'(sqx) + 62'(nay[29:0] * nay[29:0]);
          srem  <= '0;
          sroot <= '0;
          cnt   <= 6'd30;
          state <= S_SQRT;
        end
        // Integer square root, two radicand bits a cycle
        S_SQRT: begin
          sv <= sv << 2;
          if (rem_t >= trial) begin
            srem  <= 33'(rem_t - trial);
            sroot <= {sroot[29:0], 1'b1};
          end else begin
            srem  <= 33'(rem_t);
            sroot <= {sroot[29:0], 1'b0};
          end
          if (cnt == '0) begin
            state <= S_DIV;
            cnt   <= 6'd32;
          end else begin
            cnt <= cnt - 6'd1;
          end
        end
        // Two restoring dividers by the length, one quotient bit a cycle
        S_DIV: begin
          if (cnt == 6'd32) begin
            dremx <= 31'(numx[60:32]);
            dlowx <= numx[31:0];
            dremy <= 31'(numy[60:32]);
            dlowy <= numy[31:0];
            qx    <= '0;
            qy    <= '0;
            cnt   <= cnt - 6'd1;
          end else begin
            dlowx <= dlowx << 1;
            dlowy <= dlowy << 1;
            if (r2x >= {1'b0, sroot}) begin
              dremx <= 31'(r2x - {1'b0, sroot});
              qx    <= {qx[30:0], 1'b1};
            end else begin
              dremx <= r2x[30:0];
              qx    <= {qx[30:0], 1'b0};
            end
            if (r2y >= {1'b0, sroot}) begin
              dremy <= 31'(r2y - {1'b0, sroot});
              qy    <= {qy[30:0], 1'b1};
            end else begin
              dremy <= r2y[30:0];
              qy    <= {qy[30:0], 1'b0};
            end
            if (cnt == '0) begin
              state <= S_MX;
            end else begin
              cnt <= cnt - 6'd1;
            end
          end
        end
        S_MX: begin
          pm    <= qx * cfg.half_width;
          state <= S_MY;
        end
        S_MY: begin
          offx  <= 27'((pm + 56'd536870912) >> 30);
          pm    <= qy * cfg.half_width;
          state <= S_OY;
        end
        S_OY: begin
          offy  <= 27'((pm + 56'd536870912) >> 30);
          state <= S_VERT;
        end
        S_VERT: begin
          ux         <= sat32(xpos + oxs);
          lx         <= sat32(xpos - oxs);
          uy         <= sat32(48'(yp) + oys);
          ly         <= sat32(48'(yp) - oys);
          upper_sent <= 1'b0;
          state      <= S_OUT;
        end
        // Hold each vertex until the request is taken
        S_OUT: begin
          if (out_ready) begin
            if (upper_sent) begin
              upper_sent <= 1'b0;
              state      <= S_IDLE;
            end else begin
              upper_sent <= 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[test/wtle_vertex_checker.sv]
// Vertex checker: predicts extruded strip vertices from observed requests and compares.
`default_nettype none
module wtle_vertex_checker
  import wtle_pkg::*;
#(
  parameter int MAX_SAMPLES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [15:0] s_tdata,
  input  wire logic        s_tlast,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [87:0] m_tdata,
  input  wire logic        m_tuser,
  input  wire logic        m_tlast,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output int               mismatches,
  output int               outstanding,
  output int               samples_seen,
  output int               vertices_seen
);

  typedef struct {
    logic [31:0] vx;
    logic [31:0] vy;
    logic        lower;
    logic [16:0] tt;
    logic        fin;
  } vertex_t;

  vertex_t expected_vertices[$];

  // Shadow configuration and sample window
  longint left_q, center_q;
  longint unsigned xstep_q, amp_q, hw_q, tstep_q;
  longint prev_s, cur_s;
  int     fill;
  longint unsigned pidx;

  task automatic report(input string what, input longint unsigned got,
                        input longint unsigned want);
    if (mismatches < 30) begin
      $display("mismatch vertex %0d: %s got %h want %h", vertices_seen, what, got, want);
    end
    mismatches++;
  endtask

  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic longint unsigned root64(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint sample_y(input longint s);
    longint p;
    p = s * longint'(amp_q) + 16384;
    return center_q - (p >>> 15);
  endfunction

  // Compute the signed normal offset for chord (dx, dy)
  task automatic normal_offset(input longint dx, input longint dy,
                               output longint ox, output longint oy);
    longint unsigned ax, ay, mx, len, nxm, nym, offx, offy;
    ax = dx < 0 ? longint'(-dx) : dx;
    ay = dy < 0 ? longint'(-dy) : dy;
    mx = ax > ay ? ax : ay;
    if (mx < (64'd1 << 31) && ax * ax + ay * ay < 64'd4295) begin
      ox = 0;
      oy = longint'(hw_q);
    end else begin
      while (mx >= (64'd1 << 30)) begin
        ax = ax >> 1; ay = ay >> 1; mx = mx >> 1;
      end
      while (mx < (64'd1 << 29)) begin
        ax = ax << 1; ay = ay << 1; mx = mx << 1;
      end
      len  = root64(ax * ax + ay * ay);
      nxm  = ((ay << 30) + len / 2) / len;
      nym  = ((ax << 30) + len / 2) / len;
      offx = (nxm * hw_q + (64'd1 << 29)) >> 30;
      offy = (nym * hw_q + (64'd1 << 29)) >> 30;
      ox = dy > 0 ? -longint'(offx) : longint'(offx);
      oy = dx < 0 ? -longint'(offy) : longint'(offy);
    end
  endtask

  // Queue the upper and lower vertex of one point
  task automatic extrude_point(input longint unsigned idx, input longint s,
                               input longint dx, input longint dy, input bit fin);
    longint x, y, ox, oy;
    longint unsigned t;
    vertex_t v;
    x = left_q + longint'(idx * xstep_q);
    y = sample_y(s);
    t = idx * tstep_q;
    if (t > 65536) t = 65536;
    normal_offset(dx, dy, ox, oy);
    v.vx = clamp32(x + ox); v.vy = clamp32(y + oy); v.lower = 1'b0; v.tt = 17'(t);
    v.fin = 1'b0;
    expected_vertices = {expected_vertices, v};
    v.vx = clamp32(x - ox); v.vy = clamp32(y - oy); v.lower = 1'b1; v.fin = fin;
    expected_vertices = {expected_vertices, v};
  endtask

  task automatic take_sample(input longint s, input bit last);
    longint unsigned nidx;
    if (fill == 0) begin
      cur_s = s;
      pidx = 0;
      fill = last ? 0 : 1;
    end else begin
      if (fill == 1) begin
        extrude_point(pidx, cur_s, longint'(xstep_q), sample_y(s) - sample_y(cur_s), 0);
      end else begin
        extrude_point(pidx, cur_s, 2 * longint'(xstep_q), sample_y(s) - sample_y(prev_s), 0);
      end
      nidx = (pidx + 1 < MAX_SAMPLES) ? pidx + 1 : MAX_SAMPLES - 1;
      if (last) begin
        extrude_point(nidx, s, longint'(xstep_q), sample_y(s) - sample_y(cur_s), 1);
        prev_s = 0; cur_s = 0; fill = 0; pidx = 0;
      end else begin
        prev_s = cur_s; cur_s = s; fill = 2; pidx = nidx;
      end
    end
  endtask

  assign outstanding = expected_vertices.size();

  initial begin
    mismatches = 0;
    samples_seen = 0;
    vertices_seen = 0;
  end

  always @(posedge clk) begin
    vertex_t w;
    if (rst) begin
      left_q = 0; xstep_q = 65536; center_q = 0; amp_q = 65536;
      hw_q = 65536; tstep_q = 16;
      prev_s = 0; cur_s = 0; fill = 0; pidx = 0;
      expected_vertices.delete();
    end else begin
      // Compare each accepted vertex with the oldest prediction
      if (m_tvalid && m_tready) begin
        if (expected_vertices.size() == 0) begin
          report("unexpected vertex", m_tdata[63:0], 0);
        end else begin
          w = expected_vertices.pop_front();
          if (m_tdata[31:0] !== w.vx) report("vert_x", m_tdata[31:0], w.vx);
          if (m_tdata[63:32] !== w.vy) report("vert_y", m_tdata[63:32], w.vy);
          if (m_tdata[80:64] !== w.tt) report("tex_t", m_tdata[80:64], w.tt);
          if (m_tuser !== w.lower) report("lower_side", m_tuser, w.lower);
          if (m_tlast !== w.fin) report("run_end", m_tlast, w.fin);
        end
        vertices_seen++;
      end
      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_LEFT_X:     left_q = longint'($signed(cfg_data));
          REG_X_STEP:     xstep_q = cfg_data[30:0];
          REG_CENTER_Y:   center_q = longint'($signed(cfg_data));
          REG_AMPLITUDE:  amp_q = cfg_data[30:0];
          REG_HALF_WIDTH: hw_q = cfg_data[23:0];
          REG_T_STEP:     tstep_q = cfg_data[16:0];
          default: ;
        endcase
      end
      // Predict from each accepted sample request
      if (s_tvalid && s_tready) begin
        take_sample(longint'($signed(s_tdata)), s_tlast);
        samples_seen++;
      end
    end
  end

endmodule
`default_nettype wire

[test/waveform_thick_line_extruder_top_tb.sv]
// Testbench top: drives samples and register writes into the extruder and gives the verdict.
`default_nettype none
module waveform_thick_line_extruder_top_tb
  import wtle_pkg::*;
();

  localparam longint CYCLE_LIMIT = 4000000;
  localparam int     DRAIN_CYCLES = 300;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [15:0] s_tdata = 0;
  logic        s_tlast = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [87:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = 0;
  logic [31:0] cfg_data = 0;

  int     mismatches, outstanding, samples_seen, vertices_seen;
  longint cycles = 0;
  int     runs_sent = 0;
  int     settings_used = 0;
  logic signed [15:0] last_value = 0;

  waveform_thick_line_extruder_top DUT (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
    .cfg_we, .cfg_index, .cfg_data
  );

  wtle_vertex_checker chk (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
    .cfg_we, .cfg_index, .cfg_data,
    .mismatches, .outstanding, .samples_seen, .vertices_seen
  );

  always #6 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Stall the vertex side in changing modes
  int sink_mode = 0;
  int sink_count = 0;
  always @(negedge clk) begin
    if (sink_count == 0) begin
      sink_mode = $urandom_range(0, 3);
      sink_count = $urandom_range(20, 150);
    end
    sink_count--;
    if (sink_mode == 0) m_tready <= 1'b1;
    else if (sink_mode == 1) m_tready <= ($urandom_range(0, 1) == 1);
    else if (sink_mode == 2) m_tready <= ($urandom_range(0, 5) == 0);
    else m_tready <= (sink_count % 40) < 30;
  end

  // Present one sample request, hold until accepted, then maybe pause
  int burst_left = 0;
  task automatic send_sample(input logic [15:0] value, input logic last);
    int gap;
    s_tvalid <= 1;
    s_tdata  <= value;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    last_value = value;
    if (last) runs_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = $urandom_range(0, 140);
      if (gap > 0) begin
        s_tvalid <= 0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
  endtask

  task automatic load_settings(input logic [31:0] lx, input logic [30:0] xs,
                               input logic [31:0] cy, input logic [30:0] am,
                               input logic [23:0] hw, input logic [16:0] ts);
    write_reg(REG_LEFT_X, lx);
    write_reg(REG_X_STEP, {1'b0, xs});
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_AMPLITUDE, {1'b0, am});
    write_reg(REG_HALF_WIDTH, {8'd0, hw});
    write_reg(REG_T_STEP, {15'd0, ts});
    settings_used++;
  endtask

  // Let every expected vertex arrive, then let the back end settle
  task automatic drain();
    s_tvalid <= 0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_sample();
    logic signed [15:0] v;
    case ($urandom_range(0, 4))
      0: v = 16'($urandom);
      1: v = $signed(16'($urandom_range(0, 600))) - 16'sd300;
      2: v = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      3: v = last_value;
      default: v = last_value + $signed(16'($urandom_range(0, 2000))) - 16'sd1000;
    endcase
    return v;
  endfunction

  // Random runs of mostly useful length, closed by a final sample
  task automatic random_runs(input int n_items);
    int run_len, k;
    while (n_items > 0) begin
      run_len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 14);
      if (run_len > n_items) run_len = n_items < 2 ? 2 : n_items;
      for (k = 0; k < run_len; k++) send_sample(pick_sample(), k == run_len - 1);
      n_items -= run_len;
    end
    drain();
  endtask

  int p;

  initial begin
    repeat (5) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Default registers: lone sample, extremes, flat run
    send_sample(16'h7fff, 1);
    send_sample(16'h8000, 0);
    send_sample(16'h7fff, 1);
    send_sample(16'h0000, 0);
    send_sample(16'h0000, 0);
    send_sample(16'h0000, 1);
    send_sample(16'h8000, 0);
    send_sample(16'h7fff, 0);
    send_sample(16'h8000, 0);
    send_sample(16'h0001, 1);
    drain();

    // Zero step and zero gain: every chord degenerate
    load_settings(32'h0001_0000, 31'd0, 32'h0010_0000, 31'd0, 24'h02_8000, 17'd0);
    send_sample(16'h1234, 0);
    send_sample(16'hedcb, 0);
    send_sample(16'h7fff, 1);
    drain();

    // Extreme coordinates, widths and t steps: saturated vertices
    load_settings(32'h7fff_ffff, 31'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff,
                  24'hff_ffff, 17'd65536);
    send_sample(16'h8000, 0);
    send_sample(16'h7fff, 0);
    send_sample(16'h0000, 0);
    send_sample(16'h8000, 1);
    drain();
    load_settings(32'h8000_0000, 31'd1, 32'h7fff_ffff, 31'd1, 24'd0, 17'h1ffff);
    send_sample(16'h7fff, 0);
    send_sample(16'h8000, 0);
    send_sample(16'h7fff, 1);
    drain();

    // Randomized settings with random runs
    for (p = 0; p < 6; p++) begin
      load_settings($urandom,
                    ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 400000)),
                    $urandom,
                    ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 9000000)),
                    ($urandom_range(0, 1) == 0) ? 24'($urandom) : 24'($urandom_range(0, 400000)),
                    ($urandom_range(0, 3) == 0) ? 17'($urandom) : 17'($urandom_range(0, 2000)));
      random_runs(58);
    end

    $display("sent %0d samples in %0d runs over %0d register settings",
             samples_seen, runs_sent, settings_used + 1);
    $display("checked %0d vertices including lone-sample, degenerate and saturated cases",
             vertices_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire
